### hdl/wsfd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_pkg: shared types and constants of the frame deframer
// Queue entry layout, length codes and result kinds.
// ----------------------------------------------------------------------------
package wsfd_pkg;

	localparam int LEN_W       = 63;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [6:0] LEN_CODE_16   = 7'd126;
	localparam logic [6:0] LEN_CODE_64   = 7'd127;
	localparam logic [3:0] EXT_BYTES_16  = 4'd2;
	localparam logic [3:0] EXT_BYTES_64  = 4'd8;
	localparam logic [2:0] KEY_BYTES     = 3'd4;

	localparam logic KIND_HEADER  = 1'b0;
	localparam logic KIND_PAYLOAD = 1'b1;

	// One classified beat: header fields, raw payload byte and its key byte.
	typedef struct packed {
		logic             kind;
		logic             fin;
		logic [2:0]       rsv;
		logic [3:0]       opcode;
		logic             masked;
		logic [LEN_W-1:0] length;
		logic [7:0]       data;
		logic [7:0]       key;
		logic             last;
	} wsfd_entry_t;

endpackage : wsfd_pkg
`default_nettype wire

### hdl/wsfd_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_front: header parser
// Walk the frame header one byte a beat and push header and payload entries.
// ----------------------------------------------------------------------------
module wsfd_front
	import wsfd_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        rx_valid,
	output logic             rx_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        q_full,
	output logic             push,
	output wsfd_entry_t      push_entry
);

	typedef enum logic [2:0] {
		PH_FIRST,
		PH_SECOND,
		PH_EXTLEN,
		PH_KEY,
		PH_PAYLOAD
	} phase_t;

	phase_t           phase_q, phase_d;
	logic [3:0]       ext_left_q, ext_left_d;
	logic [LEN_W-1:0] length_q, length_d;
	logic [31:0]      key_q, key_d;
	logic [2:0]       key_left_q, key_left_d;
	logic [LEN_W-1:0] pay_left_q, pay_left_d;
	logic [1:0]       key_idx_q, key_idx_d;
	logic [7:0]       hdr_q, hdr_d;
	logic             masked_q, masked_d;

	logic             fire;
	logic             len_done;
	logic             hdr_emit;
	logic             pay_last;
	logic [7:0]       key_byte;
	logic [6:0]       len7;

	assign rx_ready = !q_full;
	assign fire     = rx_valid && rx_ready;
	assign len7     = rx_byte[6:0];
	assign pay_last = (pay_left_q <= LEN_W'(1));

	always_comb begin
		case (key_idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
	end

	always_comb begin
		phase_d    = phase_q;
		ext_left_d = ext_left_q;
		length_d   = length_q;
		key_d      = key_q;
		key_left_d = key_left_q;
		pay_left_d = pay_left_q;
		key_idx_d  = key_idx_q;
		hdr_d      = hdr_q;
		masked_d   = masked_q;
		len_done   = 1'b0;
		hdr_emit   = 1'b0;
		push       = 1'b0;

		case (phase_q)
			PH_SECOND: begin
				masked_d = rx_byte[7];
				length_d = '0;
				if (len7 == LEN_CODE_16) begin
					ext_left_d = EXT_BYTES_16;
					phase_d    = PH_EXTLEN;
				end else if (len7 == LEN_CODE_64) begin
					ext_left_d = EXT_BYTES_64;
					phase_d    = PH_EXTLEN;
				end else begin
					length_d = LEN_W'(len7);
					len_done = 1'b1;
				end
			end
			PH_EXTLEN: begin
				// the top length bit falls off the 63-bit register
				length_d   = {length_q[LEN_W-9:0], rx_byte};
				ext_left_d = ext_left_q - 4'd1;
				len_done   = (ext_left_q == 4'd1);
			end
			PH_KEY: begin
				key_d      = {key_q[23:0], rx_byte};
				key_left_d = key_left_q - 3'd1;
				hdr_emit   = (key_left_q == 3'd1);
			end
			PH_PAYLOAD: begin
				push       = 1'b1;
				key_idx_d  = key_idx_q + 2'd1;
				pay_left_d = pay_left_q - LEN_W'(1);
				if (pay_last) begin
					pay_left_d = '0;
					phase_d    = PH_FIRST;
				end
			end
			default: begin
				hdr_d   = rx_byte;
				phase_d = PH_SECOND;
			end
		endcase

		if (len_done) begin
			if (masked_d) begin
				key_left_d = KEY_BYTES;
				key_d      = '0;
				phase_d    = PH_KEY;
			end else begin
				key_d    = '0;
				hdr_emit = 1'b1;
			end
		end

		if (hdr_emit) begin
			push = 1'b1;
			if (length_d == '0) begin
				phase_d = PH_FIRST;
			end else begin
				pay_left_d = length_d;
				key_idx_d  = 2'd0;
				phase_d    = PH_PAYLOAD;
			end
		end

		push = push && fire;
	end

	always_comb begin
		push_entry.fin    = hdr_q[7];
		push_entry.rsv    = hdr_q[6:4];
		push_entry.opcode = hdr_q[3:0];
		push_entry.masked = masked_d;
		push_entry.length = length_d;
		if (phase_q == PH_PAYLOAD) begin
			push_entry.kind = KIND_PAYLOAD;
			push_entry.data = rx_byte;
			push_entry.key  = key_byte;
			push_entry.last = pay_last;
		end else begin
			push_entry.kind = KIND_HEADER;
			push_entry.data = 8'd0;
			push_entry.key  = 8'd0;
			push_entry.last = (length_d == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_FIRST;
			ext_left_q <= '0;
			length_q   <= '0;
			key_q      <= '0;
			key_left_q <= '0;
			pay_left_q <= '0;
			key_idx_q  <= '0;
			hdr_q      <= '0;
			masked_q   <= 1'b0;
		end else if (fire) begin
			phase_q    <= phase_d;
			ext_left_q <= ext_left_d;
			length_q   <= length_d;
			key_q      <= key_d;
			key_left_q <= key_left_d;
			pay_left_q <= pay_left_d;
			key_idx_q  <= key_idx_d;
			hdr_q      <= hdr_d;
			masked_q   <= masked_d;
		end
	end

endmodule : wsfd_front
`default_nettype wire

### hdl/wsfd_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_queue: entry queue between parser and output stage
// Small circular buffer of classified beats.
// ----------------------------------------------------------------------------
module wsfd_queue
	import wsfd_pkg::*;
#(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  wire wsfd_entry_t  push_entry,
	output logic              full,
	input  wire logic         pop,
	output logic              head_valid,
	output wsfd_entry_t       head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	wsfd_entry_t      store_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = store_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(DEPTH - 1)) begin
			return '0;
		end
		return p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			store_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

endmodule : wsfd_queue
`default_nettype wire

### hdl/wsfd_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_back: unmask and result register
// Pop queue entries, XOR payload bytes with their key byte, hold the result.
// ----------------------------------------------------------------------------
module wsfd_back
	import wsfd_pkg::*;
(
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         head_valid,
	input  wire wsfd_entry_t  head_entry,
	output logic              pop,
	output logic              res_valid,
	input  wire logic         res_ready,
	output wsfd_entry_t       res_entry
);

	logic        valid_q;
	wsfd_entry_t res_q;
	wsfd_entry_t pop_entry;

	assign pop       = head_valid && (!valid_q || res_ready);
	assign res_valid = valid_q;
	assign res_entry = res_q;

	// Unmask the head entry on its way into the result register.
	always_comb begin
		pop_entry      = head_entry;
		pop_entry.data = head_entry.data ^ head_entry.key;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (res_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			res_q <= pop_entry;
		end
	end

endmodule : wsfd_back
`default_nettype wire

### hdl/websocket_frame_deframer_core.sv
`default_nettype none
// Path: the beat that completes a result is stored in the queue, then in the result register.
// Throughput: one byte per cycle, for header and payload bytes alike, while the queue has room.
// The parser takes a byte whenever its two-entry queue has room; the output
// register drains one entry a cycle while it is empty or res_ready is high, so a
// stalled result never blocks input until the queue fills.
// Reset: arst_n clears parser state, queue pointers and result valid at once.
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core: frame byte stream to header and payload beats
// Parse each frame header, emit one header beat and one unmasked beat per payload byte.
// ----------------------------------------------------------------------------
module websocket_frame_deframer_core
	import wsfd_pkg::*;
#(
	parameter int QueueDepth = QUEUE_DEPTH
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             rx_valid,
	output logic                  rx_ready,
	input  wire logic [7:0]       rx_byte,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output logic                  kind,
	output logic                  fin,
	output logic [2:0]            rsv,
	output logic [3:0]            opcode,
	output logic                  masked,
	output logic [LEN_W-1:0]      payload_length,
	output logic [7:0]            data_byte,
	output logic                  last
);

	// Front: parser writes classified beats into the queue.
	logic        q_full;
	logic        push;
	wsfd_entry_t push_entry;

	// Back: output stage pops the queue head.
	logic        pop;
	logic        head_valid;
	wsfd_entry_t head_entry;
	wsfd_entry_t res_entry;

	wsfd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx_valid   (rx_valid),
		.rx_ready   (rx_ready),
		.rx_byte    (rx_byte),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	wsfd_queue #(
		.DEPTH (QueueDepth)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	wsfd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_entry  (res_entry)
	);

	// Fan the held result out to its field ports; the key byte stays inside.
	assign kind           = res_entry.kind;
	assign fin            = res_entry.fin;
	assign rsv            = res_entry.rsv;
	assign opcode         = res_entry.opcode;
	assign masked         = res_entry.masked;
	assign payload_length = res_entry.length;
	assign data_byte      = res_entry.data;
	assign last           = res_entry.last;

endmodule : websocket_frame_deframer_core
`default_nettype wire

### hdl/wsfd_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// wsfd_checker: port-level checks of the frame deframer
// Result stability under stall, zero data on header beats and last consistency.
// ----------------------------------------------------------------------------
module wsfd_checker
	import wsfd_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             res_valid,
	input wire logic             res_ready,
	input wire logic             kind,
	input wire logic [LEN_W-1:0] payload_length,
	input wire logic [7:0]       data_byte,
	input wire logic             last
);

	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(data_byte) && $stable(last))
	else $error("stalled result changed");

	a_header_zero_data: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_HEADER |-> data_byte == 8'd0)
	else $error("header beat carries data");

	a_empty_frame_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_HEADER && payload_length == '0 |-> last)
	else $error("empty frame header not marked last");

	a_single_byte_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && kind == KIND_PAYLOAD && payload_length == LEN_W'(1) |-> last)
	else $error("one-byte payload not marked last");

endmodule : wsfd_checker

bind websocket_frame_deframer_core wsfd_checker u_wsfd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.res_valid      (res_valid),
	.res_ready      (res_ready),
	.kind           (kind),
	.payload_length (payload_length),
	.data_byte      (data_byte),
	.last           (last)
);
`default_nettype wire
